// ===== rtl/core/r16x_pkg.sv =====
// Shared types and constants for the 16-bit register machine executor.
package r16x_pkg;

  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_READ    = 2'd1;
  localparam logic [1:0] REQ_EXEC    = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  localparam logic [15:0] PC_WORD    = 16'hFFF0;
  localparam logic [15:0] FAULT_WORD = 16'hFFF1;
  localparam logic [15:0] PORT_WORD  = 16'hFFF2;
  localparam logic [15:0] DSP_TOP    = 16'hFFEF;
  localparam logic [15:0] DSP_LIMIT  = 16'hFBEF;
  localparam logic [15:0] RSP_TOP    = 16'hFBEF;
  localparam logic [15:0] RSP_LIMIT  = 16'hF7EF;

  localparam logic [15:0] FLT_DSP_OVER  = 16'd1;
  localparam logic [15:0] FLT_DSP_UNDER = 16'd2;
  localparam logic [15:0] FLT_RSP_OVER  = 16'd3;
  localparam logic [15:0] FLT_RSP_UNDER = 16'd4;
  localparam logic [15:0] FLT_DIV_ZERO  = 16'd5;

  localparam logic [4:0] OP_LDI  = 5'd1;
  localparam logic [4:0] OP_LOD  = 5'd2;
  localparam logic [4:0] OP_STR  = 5'd3;
  localparam logic [4:0] OP_CALL = 5'd4;
  localparam logic [4:0] OP_RET  = 5'd5;
  localparam logic [4:0] OP_PUSH = 5'd6;
  localparam logic [4:0] OP_POP  = 5'd7;
  localparam logic [4:0] OP_MOV  = 5'd8;
  localparam logic [4:0] OP_ADD  = 5'd9;
  localparam logic [4:0] OP_SUB  = 5'd10;
  localparam logic [4:0] OP_MUL  = 5'd11;
  localparam logic [4:0] OP_DIV  = 5'd12;
  localparam logic [4:0] OP_MOD  = 5'd13;
  localparam logic [4:0] OP_INC  = 5'd14;
  localparam logic [4:0] OP_DEC  = 5'd15;
  localparam logic [4:0] OP_SHL  = 5'd16;
  localparam logic [4:0] OP_SHR  = 5'd17;
  localparam logic [4:0] OP_AND  = 5'd18;
  localparam logic [4:0] OP_NAND = 5'd19;
  localparam logic [4:0] OP_OR   = 5'd20;
  localparam logic [4:0] OP_NOR  = 5'd21;
  localparam logic [4:0] OP_XOR  = 5'd22;
  localparam logic [4:0] OP_CMP  = 5'd23;
  localparam logic [4:0] OP_JMP  = 5'd24;
  localparam logic [4:0] OP_BZ   = 5'd25;
  localparam logic [4:0] OP_BNS  = 5'd28;
  localparam logic [4:0] OP_HALT = 5'd31;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] mem_address;
    logic [15:0] write_word;
  } req_t;

  typedef struct packed {
    logic [15:0] read_word;
    logic [15:0] next_pc;
    logic        halted;
    logic        port_valid;
    logic [15:0] port_value;
  } rsp_t;

endpackage

// ===== rtl/core/risc16_instruction_executor.sv =====
// Top level: 16-bit register machine executor, front queue plus execution back end.
// Throughput: one transaction at a time in the back end, set by the single memory read port
// (fetch, immediate, data access and port check each take a read) and the serial divider.
// Reset: synchronous; after rst a clearing pass zeroes memory, during which
// items queue (two deep) but none execute.
module risc16_instruction_executor import r16x_pkg::*; #(
  parameter int MEM_WORDS = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [15:0] mem_address,
  input  logic [15:0] write_word,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] read_word,
  output logic [15:0] next_pc,
  output logic        halted,
  output logic        port_valid,
  output logic [15:0] port_value
);

  logic q_valid, q_take, r_valid;
  req_t q_data;
  rsp_t r_data;

  r16x_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full),
    .req_type(req_type), .mem_address(mem_address), .write_word(write_word),
    .q_valid(q_valid), .q_data(q_data), .q_take(q_take)
  );

  r16x_back #(.MEM_WORDS(MEM_WORDS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_take(q_take),
    .r_valid(r_valid), .r_data(r_data), .r_take(pop)
  );

  assign empty      = !r_valid;
  assign read_word  = r_data.read_word;
  assign next_pc    = r_data.next_pc;
  assign halted     = r_data.halted;
  assign port_valid = r_data.port_valid;
  assign port_value = r_data.port_value;

endmodule

// ===== rtl/core/r16x_front.sv =====
// Request front end: two-entry input queue that accepts and holds transactions.
module r16x_front import r16x_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  logic [1:0]  req_type,
  input  logic [15:0] mem_address,
  input  logic [15:0] write_word,
  output logic  q_valid,
  output req_t  q_data,
  input  logic  q_take
);

  req_t        slot [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;
  logic        do_push, do_pop;

  assign full    = (count == 2'd2);
  assign q_valid = (count != 2'd0);
  assign q_data  = slot[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      // unknown request types fold into a no-op with type kept
      slot[wr_ptr].req_type    <= req_type;
      slot[wr_ptr].mem_address <= mem_address;
      slot[wr_ptr].write_word  <= write_word;
    end
  end

endmodule

// ===== rtl/core/r16x_divider.sv =====
// Unsigned 16-bit restoring divider, one quotient bit per cycle.
module r16x_divider (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [15:0] dividend,
  input  logic [15:0] divisor,
  output logic        done,
  output logic [15:0] quotient,
  output logic [15:0] remainder
);

  logic [15:0] den;
  logic [4:0]  cnt;
  logic        busy;
  logic [16:0] trial;

  assign trial = {remainder, quotient[15]} - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd16;
      end else if (busy) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      den       <= divisor;
      quotient  <= dividend;
      remainder <= 16'd0;
    end else if (busy) begin
      if (!trial[16]) begin
        remainder <= trial[15:0];
        quotient  <= {quotient[14:0], 1'b1};
      end else begin
        remainder <= {remainder[14:0], quotient[15]};
        quotient  <= {quotient[14:0], 1'b0};
      end
    end
  end

endmodule

// ===== rtl/core/r16x_back.sv =====
// Execution back end: memory, register file and the instruction sequencer.
module r16x_back import r16x_pkg::*; #(
  parameter int MEM_WORDS = 65536
) (
  input  logic clk,
  input  logic rst,
  input  logic q_valid,
  input  req_t q_data,
  output logic q_take,
  output logic r_valid,
  output rsp_t r_data,
  input  logic r_take
);

  typedef enum logic [14:0] {
    S_CLEAR  = 15'b000000000000001,
    S_IDLE   = 15'b000000000000010,
    S_FETCH  = 15'b000000000000100,
    S_DECODE = 15'b000000000001000,
    S_IMM    = 15'b000000000010000,
    S_ADDR   = 15'b000000000100000,
    S_LOAD   = 15'b000000001000000,
    S_DIVW   = 15'b000000010000000,
    S_PORTR  = 15'b000000100000000,
    S_PORTC  = 15'b000001000000000,
    S_MEMRD  = 15'b000010000000000,
    S_MEMWT  = 15'b000100000000000,
    S_RESP   = 15'b001000000000000,
    S_IMMW   = 15'b010000000000000,
    S_LOADW  = 15'b100000000000000
  } state_t;

  state_t state;

  logic [15:0] mem [MEM_WORDS];
  logic        mwe;
  logic [15:0] mwa, mwd, mra, mrd;

  logic [15:0] regs [8];
  logic [15:0] pc, dsp, rsp;
  logic [3:0]  flags;
  logic [15:0] ins, addr;
  logic [15:0] clr_addr;
  logic        ret_pending;
  rsp_t        res;

  logic [4:0]  op;
  logic [15:0] x, y, alu, diff, rel;
  logic        dv_start, dv_done;
  logic [15:0] dv_q, dv_r;

  always_ff @(posedge clk) begin
    if (mwe) mem[mwa] <= mwd;
    mrd <= mem[mra];
  end

  r16x_divider u_div (
    .clk(clk), .rst(rst), .start(dv_start), .dividend(x), .divisor(y),
    .done(dv_done), .quotient(dv_q), .remainder(dv_r)
  );

  assign op   = ins[15:11];
  assign x    = regs[ins[10:8]];
  assign y    = regs[ins[7:5]];
  assign diff = x - y;
  assign rel  = pc + {{5{ins[10]}}, ins[10:0]};
  assign r_valid = (state == S_RESP);
  assign r_data  = res;
  assign q_take  = (state == S_IDLE) && q_valid;

  always_comb begin
    case (op)
      OP_ADD:  alu = x + y;
      OP_SUB:  alu = diff;
      OP_INC:  alu = x + 16'd1;
      OP_DEC:  alu = x - 16'd1;
      OP_SHL:  alu = {x[14:0], 1'b0};
      OP_SHR:  alu = {1'b0, x[15:1]};
      OP_AND:  alu = x & y;
      OP_NAND: alu = ~(x & y);
      OP_OR:   alu = x | y;
      OP_NOR:  alu = ~(x | y);
      OP_XOR:  alu = x ^ y;
      default: alu = 16'(x * y);
    endcase
  end

  // memory port control
  always_comb begin
    mwe = 1'b0;
    mwa = q_data.mem_address;
    mwd = q_data.write_word;
    mra = q_data.mem_address;
    dv_start = 1'b0;
    case (state)
      S_CLEAR: begin
        mwe = 1'b1;
        mwa = clr_addr;
        mwd = 16'd0;
      end
      S_IDLE: begin
        if (q_valid && q_data.req_type == REQ_WRITE) mwe = 1'b1;
        if (q_valid && q_data.req_type == REQ_EXEC) begin
          mwe = 1'b1;
          mwa = PC_WORD;
          mwd = pc;
          mra = pc;
        end
      end
      S_DECODE: begin
        mra = pc + 16'd1;
        if ((op == OP_DIV || op == OP_MOD) && y != 16'd0) dv_start = 1'b1;
        if (op == OP_STR && ins[10]) begin
          mwe = 1'b1;
          mwa = regs[ins[2:0]] + (ins[6] ? regs[ins[5:3]] : 16'd0);
          mwd = regs[ins[9:7]];
        end
        if (op == OP_CALL) begin
          mwe = 1'b1;
          mwa = (rsp != RSP_LIMIT) ? rsp : FAULT_WORD;
          mwd = (rsp != RSP_LIMIT) ? pc + 16'd2 : FLT_RSP_OVER;
        end
        if (op == OP_RET) begin
          mra = rsp + 16'd1;
          if (rsp == RSP_TOP) begin
            mwe = 1'b1;
            mwa = FAULT_WORD;
            mwd = FLT_RSP_UNDER;
          end
        end
        if (op == OP_PUSH) begin
          mwe = 1'b1;
          mwa = (dsp != DSP_LIMIT) ? dsp : FAULT_WORD;
          mwd = (dsp != DSP_LIMIT) ? x : FLT_DSP_OVER;
        end
        if (op == OP_POP) begin
          mra = dsp + 16'd1;
          if (dsp == DSP_TOP) begin
            mwe = 1'b1;
            mwa = FAULT_WORD;
            mwd = FLT_DSP_UNDER;
          end
        end
        if ((op == OP_DIV || op == OP_MOD) && y == 16'd0) begin
          mwe = 1'b1;
          mwa = FAULT_WORD;
          mwd = FLT_DIV_ZERO;
        end
        if (op == OP_LOD && ins[10])
          mra = regs[ins[2:0]] + (ins[6] ? regs[ins[5:3]] : 16'd0);
      end
      // re-read after the decode-cycle write so a call that lands on pc+1 sees it
      S_IMMW: mra = pc + 16'd1;
      S_LOADW: begin
        if (ret_pending) mra = rsp;
        else if (op == OP_POP) mra = dsp;
        else mra = regs[ins[2:0]] + (ins[6] ? regs[ins[5:3]] : 16'd0);
      end
      S_ADDR: begin
        mra = addr;
        if (op == OP_STR) begin
          mwe = 1'b1;
          mwa = addr;
          mwd = regs[ins[9:7]];
        end
      end
      S_PORTR: mra = PORT_WORD;
      S_PORTC: begin
        if (mrd != 16'd0) begin
          mwe = 1'b1;
          mwa = PORT_WORD;
          mwd = 16'd0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= 16'd0;
      pc       <= 16'd0;
      dsp      <= DSP_TOP;
      rsp      <= RSP_TOP;
      flags    <= 4'd0;
      for (int i = 0; i < 8; i++) regs[i] <= 16'd0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 16'd1;
          if (clr_addr == 16'(MEM_WORDS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (q_valid) begin
            res <= '{16'd0, pc, 1'b0, 1'b0, 16'd0};
            case (q_data.req_type)
              REQ_EXEC:  state <= S_FETCH;
              REQ_READ:  state <= S_MEMRD;
              REQ_WRITE: state <= S_RESP;
              default:   state <= S_RESP;
            endcase
          end
        end
        S_MEMRD: begin
          res.read_word <= mrd;
          state <= S_MEMWT;
        end
        S_MEMWT: state <= S_RESP;
        S_FETCH: begin
          // pc at the pc word fetches the value just stored there
          ins <= (pc == PC_WORD) ? pc : mrd;
          state <= S_DECODE;
        end
        S_DECODE: begin
          ret_pending <= (op == OP_RET) && (rsp != RSP_TOP);
          case (op)
            OP_LDI: state <= S_IMMW;
            OP_LOD, OP_STR: begin
              if (!ins[10]) state <= S_IMMW;
              else begin
                pc <= pc + 16'd1;
                state <= (op == OP_LOD) ? S_LOADW : S_PORTR;
              end
            end
            OP_CALL: begin
              if (rsp != RSP_LIMIT) begin
                rsp <= rsp - 16'd1;
                state <= S_IMMW;
              end else state <= S_PORTR;
            end
            OP_RET: begin
              if (rsp != RSP_TOP) begin
                rsp <= rsp + 16'd1;
                state <= S_LOADW;
              end else state <= S_PORTR;
            end
            OP_PUSH: begin
              if (dsp != DSP_LIMIT) dsp <= dsp - 16'd1;
              pc <= pc + 16'd1;
              state <= S_PORTR;
            end
            OP_POP: begin
              pc <= pc + 16'd1;
              if (dsp != DSP_TOP) begin
                dsp <= dsp + 16'd1;
                state <= S_LOADW;
              end else state <= S_PORTR;
            end
            OP_MOV: begin
              regs[ins[7:5]] <= x;
              pc <= pc + 16'd1;
              state <= S_PORTR;
            end
            OP_DIV, OP_MOD: begin
              if (y != 16'd0) state <= S_DIVW;
              else begin
                pc <= pc + 16'd1;
                state <= S_PORTR;
              end
            end
            OP_CMP: begin
              flags <= {~diff[15], diff[15], diff != 16'd0, diff == 16'd0};
              pc <= pc + 16'd1;
              state <= S_PORTR;
            end
            OP_JMP: begin
              pc <= rel;
              state <= S_PORTR;
            end
            OP_HALT: begin
              res.halted <= 1'b1;
              state <= S_PORTR;
            end
            default: begin
              if (op >= OP_BZ && op <= OP_BNS)
                pc <= flags[2'(op - OP_BZ)] ? rel : pc + 16'd1;
              else if (op >= OP_ADD && op <= OP_XOR)
                begin
                  regs[ins[4:2]] <= alu;
                  pc <= pc + 16'd1;
                end
              else pc <= pc + 16'd1;
              state <= S_PORTR;
            end
          endcase
        end
        S_IMMW: state <= S_IMM;
        S_IMM: begin
          // mrd holds mem[pc+1]
          case (op)
            OP_LDI: begin
              regs[ins[10:8]] <= mrd;
              pc <= pc + 16'd2;
              state <= S_PORTR;
            end
            OP_CALL: begin
              pc <= mrd;
              state <= S_PORTR;
            end
            default: begin
              addr <= mrd + (ins[6] ? regs[ins[5:3]] : 16'd0);
              pc <= pc + 16'd2;
              state <= S_ADDR;
            end
          endcase
        end
        S_ADDR: begin
          if (op == OP_LOD) state <= S_LOAD;
          else state <= S_PORTR;
        end
        S_LOADW: state <= S_LOAD;
        S_LOAD: begin
          if (ret_pending) pc <= mrd;
          else if (op == OP_POP) regs[ins[10:8]] <= mrd;
          else regs[ins[9:7]] <= mrd;
          state <= S_PORTR;
        end
        S_DIVW: begin
          if (dv_done) begin
            regs[ins[4:2]] <= (op == OP_DIV) ? dv_q : dv_r;
            pc <= pc + 16'd1;
            state <= S_PORTR;
          end
        end
        S_PORTR: state <= S_PORTC;
        S_PORTC: begin
          res.next_pc <= pc;
          if (mrd != 16'd0) begin
            res.port_valid <= 1'b1;
            res.port_value <= mrd;
          end
          state <= S_RESP;
        end
        S_RESP: if (r_take) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/r16x_checker.sv =====
// Port-level checker for the executor, bound to the top level.
module r16x_checker (
  input logic        clk,
  input logic        rst,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic        halted,
  input logic        port_valid,
  input logic [15:0] port_value,
  input logic [15:0] read_word
);

  a_port_nonzero: assert property (@(posedge clk) disable iff (rst)
    (!empty && port_valid) |-> (port_value != 16'd0)) else $error("port value zero");

  a_port_clean: assert property (@(posedge clk) disable iff (rst)
    (!empty && !port_valid) |-> (port_value == 16'd0)) else $error("stray port value");

  a_halt_no_read: assert property (@(posedge clk) disable iff (rst)
    (!empty && halted) |-> (read_word == 16'd0)) else $error("halt with read data");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(read_word))) else $error("result dropped");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (empty && !full)) else $error("not empty after reset");

endmodule

bind risc16_instruction_executor r16x_checker u_chk (
  .clk(clk), .rst(rst), .full(full), .empty(empty), .pop(pop), .halted(halted),
  .port_valid(port_valid), .port_value(port_value), .read_word(read_word)
);
